FILE: rtl/esr_pkg.sv
// Shared types, codes and default sizes for the event subscription router.
package esr_pkg;

  // Default sizes
  localparam int DEF_POOL_SIZE       = 16;
  localparam int DEF_EVENT_COUNT     = 32;
  localparam int DEF_SLOTS_PER_EVENT = 8;
  localparam int DEF_GEN_BITS        = 8;

  // Command modes
  localparam logic [1:0] MODE_SUB      = 2'd0;
  localparam logic [1:0] MODE_UNSUB    = 2'd1;
  localparam logic [1:0] MODE_DISPATCH = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_EVENT  = 3'd1;
  localparam logic [2:0] ST_NO_TARGET  = 3'd2;
  localparam logic [2:0] ST_POOL_FULL  = 3'd3;
  localparam logic [2:0] ST_SLOTS_FULL = 3'd4;
  localparam logic [2:0] ST_BAD_HANDLE = 3'd5;

  // Command beat
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  event_id;
    logic        target_present;
    logic [15:0] target;
    logic [7:0]  handle_index;
  } esr_cmd_t;

  // Result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  out_handle_index;
    logic [7:0]  out_generation;
    logic [15:0] out_target;
    logic        has_target;
    logic        last;
  } esr_res_t;

  // Write strobes from the sequencer into the handle pool
  typedef struct packed {
    logic gen_we;
    logic tgt_we;
    logic act_set;
    logic act_clr;
  } esr_pool_ctl_t;

endpackage

FILE: rtl/event_subscription_router.sv
// Event subscription router top level: sequencer, result staging and output register.
//
//   channel | signals                   | direction | beat
//   cmd     | cmd_valid, cmd_ready, cmd | in        | one command (esr_cmd_t)
//   res     | res_valid, res_ready, res | out       | one result (esr_res_t)
//
// Unsubscribe, bad event and no target cases go from decode straight to the
// response stage; pool full ends the handle scan when every handle is active.
// Subscribe finds the lowest free handle, reads and bumps its generation, then
// examines slots in order until one is not live; dispatch examines every slot
// of the event. Every slot step is a slot-memory read, a generation-memory read
// and one compare in the shared check cycle. After reset a clearing sweep of
// the slot table and generation memory runs with cmd_ready low. A held result
// stalls the sequencer whenever a further beat must move into the output register.
module event_subscription_router #(
  parameter int POOL_SIZE       = esr_pkg::DEF_POOL_SIZE,
  parameter int EVENT_COUNT     = esr_pkg::DEF_EVENT_COUNT,
  parameter int SLOTS_PER_EVENT = esr_pkg::DEF_SLOTS_PER_EVENT,
  parameter int GEN_BITS        = esr_pkg::DEF_GEN_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  esr_pkg::esr_cmd_t cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output esr_pkg::esr_res_t res
);

  localparam int HW    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int JW    = (SLOTS_PER_EVENT > 1) ? $clog2(SLOTS_PER_EVENT) : 1;
  localparam int DEPTH = EVENT_COUNT * SLOTS_PER_EVENT;
  localparam int SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = 1 + HW + GEN_BITS;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_HSCAN  = 9'b000000100,
    S_GREAD  = 9'b000001000,
    S_GBUMP  = 9'b000010000,
    S_SREAD  = 9'b000100000,
    S_SGEN   = 9'b001000000,
    S_SCHECK = 9'b010000000,
    S_RESP   = 9'b100000000
  } state_t;

  state_t                 state;
  esr_pkg::esr_cmd_t      cmd_r;
  logic [SW-1:0]          slot_base;
  logic [JW-1:0]          jdx;
  logic [HW-1:0]          hdx;
  logic [GEN_BITS-1:0]    new_gen;
  esr_pkg::esr_res_t      pend;
  logic                   pend_valid;

  esr_pkg::esr_pool_ctl_t pool_ctl;
  logic [HW-1:0]          pool_handle;
  logic [HW-1:0]          gen_raddr;
  logic [GEN_BITS-1:0]    gen_q;
  logic [15:0]            tgt_q;
  logic [POOL_SIZE-1:0]   pool_active;
  logic                   pool_busy;

  logic [EW-1:0]          slot_rdata;
  logic [EW-1:0]          slot_wdata;
  logic                   slot_we;
  logic                   slot_busy;

  logic                   slot_valid;
  logic [HW-1:0]          slot_hd;
  logic [GEN_BITS-1:0]    slot_gen;
  logic                   live;
  logic                   last_slot;
  logic                   is_sub;
  logic                   evt_ok;
  logic                   hidx_ok;
  logic                   out_free;
  logic                   push;

  // Single-beat result with only a status
  function automatic esr_pkg::esr_res_t status_beat(input logic [2:0] st);
    esr_pkg::esr_res_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  // Single-beat result for a granted subscription
  function automatic esr_pkg::esr_res_t grant_beat(input logic [3:0] h,
                                                   input logic [7:0] g);
    esr_pkg::esr_res_t r;
    r                  = '0;
    r.status           = esr_pkg::ST_OK;
    r.out_handle_index = h;
    r.out_generation   = g;
    r.last             = 1'b1;
    return r;
  endfunction

  // Slot fields and the shared liveness compare
  assign slot_valid = slot_rdata[EW-1];
  assign slot_hd    = slot_rdata[EW-2 -: HW];
  assign slot_gen   = slot_rdata[GEN_BITS-1:0];
  assign live       = slot_valid && pool_active[slot_hd] && (gen_q == slot_gen);
  assign last_slot  = (jdx == JW'(SLOTS_PER_EVENT - 1));
  assign is_sub     = (cmd_r.mode == esr_pkg::MODE_SUB);
  assign evt_ok     = ({1'b0, cmd_r.event_id} < 9'(EVENT_COUNT));
  assign hidx_ok    = ({1'b0, cmd_r.handle_index} < 9'(POOL_SIZE));

  assign cmd_ready  = (state == S_IDLE) && !slot_busy && !pool_busy;
  assign out_free   = !res_valid || res_ready;

  // Pool and slot write strobes
  always_comb begin
    pool_ctl         = '0;
    pool_ctl.gen_we  = (state == S_GBUMP);
    pool_ctl.act_set = (state == S_SCHECK) && is_sub && !live;
    pool_ctl.tgt_we  = pool_ctl.act_set;
    pool_ctl.act_clr = (state == S_DECODE) && (cmd_r.mode == esr_pkg::MODE_UNSUB) && hidx_ok;
    pool_handle      = pool_ctl.act_clr ? cmd_r.handle_index[HW-1:0] : hdx;
    gen_raddr        = ((state == S_SGEN) || (state == S_SCHECK)) ? slot_hd : hdx;
    slot_we          = pool_ctl.act_set;
    slot_wdata       = {1'b1, hdx, new_gen};
  end

  // Staged result moves to the output register
  assign push = out_free && ((state == S_RESP) ||
                ((state == S_SCHECK) && !is_sub && live && pend_valid));

  esr_handle_pool #(
    .POOL_SIZE (POOL_SIZE),
    .GEN_BITS  (GEN_BITS)
  ) u_pool (
    .clk       (clk),
    .rst       (rst),
    .ctl       (pool_ctl),
    .handle    (pool_handle),
    .gen_wdata (gen_q + 1'b1),
    .tgt_wdata (cmd_r.target),
    .gen_raddr (gen_raddr),
    .tgt_raddr (slot_hd),
    .gen_q     (gen_q),
    .tgt_q     (tgt_q),
    .active    (pool_active),
    .busy      (pool_busy)
  );

  esr_slot_table #(
    .POOL_SIZE       (POOL_SIZE),
    .EVENT_COUNT     (EVENT_COUNT),
    .SLOTS_PER_EVENT (SLOTS_PER_EVENT),
    .GEN_BITS        (GEN_BITS)
  ) u_slots (
    .clk   (clk),
    .rst   (rst),
    .base  (slot_base),
    .idx   (jdx),
    .we    (slot_we),
    .wdata (slot_wdata),
    .rdata (slot_rdata),
    .busy  (slot_busy)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res <= pend;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          pend_valid <= 1'b0;
          if (cmd_valid && cmd_ready) begin
            cmd_r <= cmd;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          slot_base <= SW'(int'(cmd_r.event_id) * SLOTS_PER_EVENT);
          jdx       <= '0;
          hdx       <= '0;
          case (cmd_r.mode)
            esr_pkg::MODE_SUB: begin
              if (!evt_ok) begin
                pend       <= status_beat(esr_pkg::ST_BAD_EVENT);
                pend_valid <= 1'b1;
                state      <= S_RESP;
              end else if (!cmd_r.target_present) begin
                pend       <= status_beat(esr_pkg::ST_NO_TARGET);
                pend_valid <= 1'b1;
                state      <= S_RESP;
              end else begin
                state <= S_HSCAN;
              end
            end
            esr_pkg::MODE_UNSUB: begin
              pend       <= status_beat(hidx_ok ? esr_pkg::ST_OK : esr_pkg::ST_BAD_HANDLE);
              pend_valid <= 1'b1;
              state      <= S_RESP;
            end
            esr_pkg::MODE_DISPATCH: begin
              if (!evt_ok) begin
                pend       <= status_beat(esr_pkg::ST_BAD_EVENT);
                pend_valid <= 1'b1;
                state      <= S_RESP;
              end else begin
                state <= S_SREAD;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        // Lowest inactive handle, one per cycle
        S_HSCAN: begin
          if (!pool_active[hdx]) begin
            state <= S_GREAD;
          end else if (hdx == HW'(POOL_SIZE - 1)) begin
            pend       <= status_beat(esr_pkg::ST_POOL_FULL);
            pend_valid <= 1'b1;
            state      <= S_RESP;
          end else begin
            hdx <= hdx + 1'b1;
          end
        end
        S_GREAD: state <= S_GBUMP;
        // Generation bump is written back here and kept even if no slot is found
        S_GBUMP: begin
          new_gen <= gen_q + 1'b1;
          state   <= S_SREAD;
        end
        S_SREAD: state <= S_SGEN;
        S_SGEN:  state <= S_SCHECK;
        S_SCHECK: begin
          if (is_sub) begin
            if (!live) begin
              // Empty or stale slot takes the new handle
              pend       <= grant_beat(4'(hdx), 8'(new_gen));
              pend_valid <= 1'b1;
              state      <= S_RESP;
            end else if (last_slot) begin
              pend       <= status_beat(esr_pkg::ST_SLOTS_FULL);
              pend_valid <= 1'b1;
              state      <= S_RESP;
            end else begin
              jdx   <= jdx + 1'b1;
              state <= S_SREAD;
            end
          end else begin
            if (live) begin
              // Earlier subscriber goes out first; wait while the output is held
              if (!pend_valid || out_free) begin
                pend.status           <= esr_pkg::ST_OK;
                pend.out_handle_index <= 4'(slot_hd);
                pend.out_generation   <= 8'(slot_gen);
                pend.out_target       <= tgt_q;
                pend.has_target       <= 1'b1;
                pend.last             <= last_slot;
                pend_valid            <= 1'b1;
                if (last_slot) begin
                  state <= S_RESP;
                end else begin
                  jdx   <= jdx + 1'b1;
                  state <= S_SREAD;
                end
              end
            end else if (last_slot) begin
              if (pend_valid) begin
                pend.last <= 1'b1;
              end else begin
                pend <= status_beat(esr_pkg::ST_OK);
              end
              pend_valid <= 1'b1;
              state      <= S_RESP;
            end else begin
              jdx   <= jdx + 1'b1;
              state <= S_SREAD;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A subscribe that takes a slot leaves its handle active
  a_alloc_active: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCHECK) && is_sub && !live |=> pool_active[hdx])
    else $error("allocated handle not active");

  // No command work starts while the slot table is still being cleared
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    slot_busy |-> (state == S_IDLE))
    else $error("sequencer left idle during clearing sweep");

  // The final stage always has a staged result to deliver
  a_resp_staged: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) |-> pend_valid)
    else $error("result stage empty");

  // A beat naming a subscriber carries ok status
  a_target_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.has_target |-> (res.status == esr_pkg::ST_OK))
    else $error("subscriber beat with error status");
`endif

endmodule

FILE: rtl/esr_handle_pool.sv
// Handle pool: active flags, generation memory with clearing sweep, target memory.
module esr_handle_pool #(
  parameter int  POOL_SIZE = esr_pkg::DEF_POOL_SIZE,
  parameter int  GEN_BITS  = esr_pkg::DEF_GEN_BITS,
  localparam int HW        = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  esr_pkg::esr_pool_ctl_t ctl,
  input  logic [HW-1:0]         handle,
  input  logic [GEN_BITS-1:0]   gen_wdata,
  input  logic [15:0]           tgt_wdata,
  input  logic [HW-1:0]         gen_raddr,
  input  logic [HW-1:0]         tgt_raddr,
  output logic [GEN_BITS-1:0]   gen_q,
  output logic [15:0]           tgt_q,
  output logic [POOL_SIZE-1:0]  active,
  output logic                  busy
);

  logic [GEN_BITS-1:0] gen_mem [POOL_SIZE];
  logic [15:0]         tgt_mem [POOL_SIZE];
  logic [HW-1:0]       clr_cnt;

  // Clearing sweep of the generation memory after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_cnt <= '0;
    end else if (busy) begin
      if (clr_cnt == HW'(POOL_SIZE - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Active flags
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else begin
      if (ctl.act_set) begin
        active[handle] <= 1'b1;
      end
      if (ctl.act_clr) begin
        active[handle] <= 1'b0;
      end
    end
  end

  // Generation memory, registered read
  always_ff @(posedge clk) begin
    if (busy) begin
      gen_mem[clr_cnt] <= '0;
    end else if (ctl.gen_we) begin
      gen_mem[handle] <= gen_wdata;
    end
    gen_q <= gen_mem[gen_raddr];
  end

  // Target memory, registered read; its output is only used for live handles
  always_ff @(posedge clk) begin
    if (ctl.tgt_we) begin
      tgt_mem[handle] <= tgt_wdata;
    end
    tgt_q <= tgt_mem[tgt_raddr];
  end

endmodule

FILE: rtl/esr_slot_table.sv
// Subscriber slot table: one memory row per event, clearing sweep after reset.
module esr_slot_table #(
  parameter int  POOL_SIZE       = esr_pkg::DEF_POOL_SIZE,
  parameter int  EVENT_COUNT     = esr_pkg::DEF_EVENT_COUNT,
  parameter int  SLOTS_PER_EVENT = esr_pkg::DEF_SLOTS_PER_EVENT,
  parameter int  GEN_BITS        = esr_pkg::DEF_GEN_BITS,
  localparam int HW    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1,
  localparam int JW    = (SLOTS_PER_EVENT > 1) ? $clog2(SLOTS_PER_EVENT) : 1,
  localparam int DEPTH = EVENT_COUNT * SLOTS_PER_EVENT,
  localparam int SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int EW    = 1 + HW + GEN_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [SW-1:0] base,
  input  logic [JW-1:0] idx,
  input  logic          we,
  input  logic [EW-1:0] wdata,
  output logic [EW-1:0] rdata,
  output logic          busy
);

  logic [EW-1:0] slot_mem [DEPTH];
  logic [SW-1:0] clr_cnt;
  logic [SW-1:0] addr;

  // Row base plus slot number
  assign addr = base + SW'(idx);

  // Clearing sweep: every entry invalid, handle and generation zero
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_cnt <= '0;
    end else if (busy) begin
      if (clr_cnt == SW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Slot memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (busy) begin
      slot_mem[clr_cnt] <= '0;
    end else if (we) begin
      slot_mem[addr] <= wdata;
    end
    rdata <= slot_mem[addr];
  end

endmodule

FILE: sim/event_subscription_router_tb.sv
// Self-checking testbench for the event subscription router: directed and random commands.
module event_subscription_router_tb;

  localparam int POOL   = esr_pkg::DEF_POOL_SIZE;
  localparam int EVENTS = esr_pkg::DEF_EVENT_COUNT;
  localparam int SLOTS  = esr_pkg::DEF_SLOTS_PER_EVENT;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 84;
  localparam int WRAP_ITEMS   = 4;
  localparam int DRAIN_CYCLES = 200;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cmd_valid = 1'b0;
  logic              cmd_ready;
  esr_pkg::esr_cmd_t cmd = '0;
  logic              res_valid;
  logic              res_ready = 1'b0;
  esr_pkg::esr_res_t res;

  // Commands waiting for the driver, results waiting for the bus
  esr_pkg::esr_cmd_t pending_cmds[$];
  esr_pkg::esr_res_t expected_results[$];
  int                mismatches = 0;

  // Shadow of the handle pool and the subscriber table
  bit        pool_live   [POOL];
  bit [7:0]  pool_gen    [POOL];
  bit [15:0] pool_target [POOL];
  bit        slot_used   [EVENTS][SLOTS];
  bit [3:0]  slot_handle [EVENTS][SLOTS];
  bit [7:0]  slot_gen    [EVENTS][SLOTS];

  int cmd_gap = 0, cmd_quiet = 0;
  int res_stall = 0, res_quiet = 0;

  event_subscription_router #(
    .POOL_SIZE      (POOL),
    .EVENT_COUNT    (EVENTS),
    .SLOTS_PER_EVENT(SLOTS),
    .GEN_BITS       (esr_pkg::DEF_GEN_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long, with quiet stretches
  function automatic int next_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic esr_pkg::esr_res_t make_result(logic [2:0] st, logic [3:0] h,
                                                    logic [7:0] g, logic [15:0] t,
                                                    logic has, logic lst);
    esr_pkg::esr_res_t r;
    r.status           = st;
    r.out_handle_index = h;
    r.out_generation   = g;
    r.out_target       = t;
    r.has_target       = has;
    r.last             = lst;
    return r;
  endfunction

  // Single result carrying only a status
  function automatic esr_pkg::esr_res_t status_result(logic [2:0] st);
    return make_result(st, 4'd0, 8'd0, 16'd0, 1'b0, 1'b1);
  endfunction

  // A slot is live when its handle is active with a matching generation
  function automatic bit slot_is_live(int e, int s);
    int h;
    h = slot_handle[e][s];
    return slot_used[e][s] && pool_live[h] && pool_gen[h] == slot_gen[e][s];
  endfunction

  // Apply one accepted command to the shadow state and queue its results
  function automatic void route_command(esr_pkg::esr_cmd_t c);
    int                h;
    int                e;
    bit                placed;
    esr_pkg::esr_res_t hits[$];
    h = -1;
    e = c.event_id;
    placed = 1'b0;
    case (c.mode)
      esr_pkg::MODE_SUB: begin
        if (e >= EVENTS) begin
          expected_results.push_back(status_result(esr_pkg::ST_BAD_EVENT));
        end else if (!c.target_present) begin
          expected_results.push_back(status_result(esr_pkg::ST_NO_TARGET));
        end else begin
          for (int i = 0; i < POOL; i++)
            if (h < 0 && !pool_live[i]) h = i;
          if (h < 0) begin
            expected_results.push_back(status_result(esr_pkg::ST_POOL_FULL));
          end else begin
            // generation is bumped even if no slot is found
            pool_gen[h] = pool_gen[h] + 8'd1;
            for (int s = 0; s < SLOTS; s++) begin
              if (!placed) begin
                if (slot_used[e][s] && !slot_is_live(e, s)) begin
                  slot_used[e][s]   = 1'b0;
                  slot_handle[e][s] = '0;
                  slot_gen[e][s]    = '0;
                end
                if (!slot_used[e][s]) begin
                  slot_used[e][s]   = 1'b1;
                  slot_handle[e][s] = 4'(h);
                  slot_gen[e][s]    = pool_gen[h];
                  pool_live[h]      = 1'b1;
                  pool_target[h]    = c.target;
                  placed            = 1'b1;
                  expected_results.push_back(make_result(esr_pkg::ST_OK, 4'(h), pool_gen[h],
                                                         16'd0, 1'b0, 1'b1));
                end
              end
            end
            if (!placed)
              expected_results.push_back(status_result(esr_pkg::ST_SLOTS_FULL));
          end
        end
      end
      esr_pkg::MODE_UNSUB: begin
        if (c.handle_index >= POOL) begin
          expected_results.push_back(status_result(esr_pkg::ST_BAD_HANDLE));
        end else begin
          pool_live[c.handle_index] = 1'b0;
          expected_results.push_back(status_result(esr_pkg::ST_OK));
        end
      end
      esr_pkg::MODE_DISPATCH: begin
        if (e >= EVENTS) begin
          expected_results.push_back(status_result(esr_pkg::ST_BAD_EVENT));
        end else begin
          for (int s = 0; s < SLOTS; s++)
            if (slot_is_live(e, s))
              hits.push_back(make_result(esr_pkg::ST_OK, slot_handle[e][s], slot_gen[e][s],
                                         pool_target[slot_handle[e][s]], 1'b1, 1'b0));
          if (hits.size() == 0) begin
            expected_results.push_back(status_result(esr_pkg::ST_OK));
          end else begin
            hits[hits.size() - 1].last = 1'b1;
            foreach (hits[k]) expected_results.push_back(hits[k]);
          end
        end
      end
      default: ;  // unknown mode gives nothing
    endcase
  endfunction

  function automatic void queue_cmd(logic [1:0] m, logic [7:0] e, logic p, logic [15:0] t,
                                    logic [7:0] h);
    esr_pkg::esr_cmd_t c;
    c.mode           = m;
    c.event_id       = e;
    c.target_present = p;
    c.target         = t;
    c.handle_index   = h;
    pending_cmds.push_back(c);
  endfunction

  // Command driver: next beat once the current one is taken, with random gaps
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      cmd_gap = 0;
    end else if (!cmd_valid || cmd_ready) begin
      if (cmd_gap > 0) begin
        cmd_gap--;
        cmd_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cmd       <= pending_cmds.pop_front();
        cmd_valid <= 1'b1;
        cmd_gap = next_gap(cmd_quiet);
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on each accepted command, check each accepted result
  always @(posedge clk) begin
    esr_pkg::esr_res_t want;
    if (rst) begin
      res_ready <= 1'b0;
      res_stall = 0;
    end else begin
      if (cmd_valid && cmd_ready) route_command(cmd);
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: %p", res);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res.status);
            mismatches++;
          end
          if (res.out_handle_index !== want.out_handle_index) begin
            $error("out_handle_index: expected %0d, got %0d",
                   want.out_handle_index, res.out_handle_index);
            mismatches++;
          end
          if (res.out_generation !== want.out_generation) begin
            $error("out_generation: expected %0d, got %0d",
                   want.out_generation, res.out_generation);
            mismatches++;
          end
          if (res.out_target !== want.out_target) begin
            $error("out_target: expected %h, got %h", want.out_target, res.out_target);
            mismatches++;
          end
          if (res.has_target !== want.has_target) begin
            $error("has_target: expected %0d, got %0d", want.has_target, res.has_target);
            mismatches++;
          end
          if (res.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, res.last);
            mismatches++;
          end
        end
      end
      // receiver back-pressure
      if (res_stall > 0) begin
        res_stall--;
        res_ready <= 1'b0;
      end else begin
        res_stall = next_gap(res_quiet);
        res_ready <= (res_stall == 0);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    esr_pkg::esr_cmd_t c;
    int                counted;
    int                r;

    // error paths, ignored mode and empty dispatch
    queue_cmd(MODE_UNUSED, 8'($urandom), 1'($urandom), 16'($urandom), 8'($urandom));
    queue_cmd(esr_pkg::MODE_SUB, 8'd255, 1'b1, 16'hFFFF, 8'd0);
    queue_cmd(esr_pkg::MODE_SUB, 8'(EVENTS), 1'b0, 16'h1234, 8'd255);
    queue_cmd(esr_pkg::MODE_SUB, 8'd5, 1'b0, 16'hABCD, 8'd0);
    queue_cmd(esr_pkg::MODE_DISPATCH, 8'd255, 1'b0, 16'h0000, 8'd0);
    queue_cmd(esr_pkg::MODE_DISPATCH, 8'd0, 1'b1, 16'hFFFF, 8'd255);
    queue_cmd(esr_pkg::MODE_UNSUB, 8'd0, 1'b0, 16'h0000, 8'd255);
    queue_cmd(esr_pkg::MODE_UNSUB, 8'd255, 1'b1, 16'hFFFF, 8'(POOL));
    queue_cmd(esr_pkg::MODE_UNSUB, 8'd0, 1'b0, 16'h0000, 8'd3);   // freeing a free handle
    // fill every slot of event 0, then dispatch all of them
    queue_cmd(esr_pkg::MODE_SUB, 8'd0, 1'b1, 16'hFFFF, 8'd0);
    queue_cmd(esr_pkg::MODE_SUB, 8'd0, 1'b1, 16'h0000, 8'd0);
    for (int i = 2; i < SLOTS; i++)
      queue_cmd(esr_pkg::MODE_SUB, 8'd0, 1'b1, 16'($urandom), 8'($urandom));
    queue_cmd(esr_pkg::MODE_DISPATCH, 8'd0, 1'b0, 16'h0000, 8'd0);
    // full event: each try bumps the lowest free handle's generation
    for (int i = 0; i < WRAP_ITEMS; i++)
      queue_cmd(esr_pkg::MODE_SUB, 8'd0, 1'b1, 16'($urandom), 8'($urandom));
    // stale slot is cleared and reused
    queue_cmd(esr_pkg::MODE_UNSUB, 8'd0, 1'b0, 16'h0000, 8'd2);
    queue_cmd(esr_pkg::MODE_SUB, 8'd0, 1'b1, 16'h5A5A, 8'd0);
    queue_cmd(esr_pkg::MODE_DISPATCH, 8'd0, 1'b0, 16'h0000, 8'd0);
    // exhaust the pool on the top event
    for (int i = SLOTS; i < POOL; i++)
      queue_cmd(esr_pkg::MODE_SUB, 8'(EVENTS - 1), 1'b1, 16'($urandom), 8'($urandom));
    queue_cmd(esr_pkg::MODE_SUB, 8'(EVENTS - 1), 1'b1, 16'h0F0F, 8'd0);
    queue_cmd(esr_pkg::MODE_DISPATCH, 8'(EVENTS - 1), 1'b0, 16'h0000, 8'd0);
    queue_cmd(esr_pkg::MODE_UNSUB, 8'd0, 1'b0, 16'h0000, 8'(POOL - 1));

    // random traffic, mostly on a few busy events so slots fill and go stale
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      c.mode           = MODE_UNUSED;
      c.event_id       = 8'($urandom_range(0, 255));
      c.target_present = 1'($urandom_range(0, 1));
      c.target         = 16'($urandom_range(0, 65535));
      c.handle_index   = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 35 || (r >= 63 && r < 88)) begin
        c.mode = (r < 35) ? esr_pkg::MODE_SUB : esr_pkg::MODE_DISPATCH;
        c.event_id = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 3))
                                                 : 8'($urandom_range(0, EVENTS - 1));
        c.target_present = 1'b1;
      end else if (r < 63) begin
        c.mode = esr_pkg::MODE_UNSUB;
        c.handle_index = 8'($urandom_range(0, POOL - 1));
      end else begin
        case ($urandom_range(0, 4))
          0: begin
            c.mode = esr_pkg::MODE_SUB;
            c.event_id = 8'($urandom_range(EVENTS, 255));
          end
          1: begin
            c.mode = esr_pkg::MODE_SUB;
            c.event_id = 8'($urandom_range(0, EVENTS - 1));
            c.target_present = 1'b0;
          end
          2: begin
            c.mode = esr_pkg::MODE_DISPATCH;
            c.event_id = 8'($urandom_range(EVENTS, 255));
          end
          3: begin
            c.mode = esr_pkg::MODE_UNSUB;
            c.handle_index = 8'($urandom_range(POOL, 255));
          end
          default: c.mode = MODE_UNUSED;
        endcase
      end
      if (c.mode != MODE_UNUSED) counted++;
      pending_cmds.push_back(c);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || cmd_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_results.size() != 0)
      $error("%0d expected results never arrived", expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/esr_pkg.sv
rtl/esr_handle_pool.sv
rtl/esr_slot_table.sv
rtl/event_subscription_router.sv
sim/event_subscription_router_tb.sv
